### design/ssff_pkg.sv
// shared types, field layouts and codes of the syscall flow filter
// no dependencies; imported by every module of the block

package ssff_pkg;

    // default sizes of the policy tables
    localparam int DEF_NUM_SYSCALLS = 512;
    localparam int DEF_NUM_STATES   = 16;
    localparam int DEF_NUM_CONTEXTS = 64;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam int STATE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int ERRNO_W    = 12;

    // commands
    localparam logic [2:0] CMD_SYSCALL    = 3'd0;
    localparam logic [2:0] CMD_TRANSITION = 3'd1;
    localparam logic [2:0] CMD_TRACK      = 3'd2;
    localparam logic [2:0] CMD_UNTRACK    = 3'd3;
    localparam logic [2:0] CMD_LOAD       = 3'd4;

    // result status codes
    localparam logic [3:0] ST_ALLOWED   = 4'd0;
    localparam logic [3:0] ST_RECORDED  = 4'd1;
    localparam logic [3:0] ST_IGNORED   = 4'd2;
    localparam logic [3:0] ST_REFUSED   = 4'd3;
    localparam logic [3:0] ST_COMPAT    = 4'd4;
    localparam logic [3:0] ST_BADNUM    = 4'd5;
    localparam logic [3:0] ST_FLOW_VIOL = 4'd6;
    localparam logic [3:0] ST_FLOW_WARN = 4'd7;
    localparam logic [3:0] ST_ADMIN     = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIOL_ACTION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_NUMBER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_TRACK    = 2'd3;

    // configuration reset values
    localparam logic               RST_LEARNING_MODE = 1'b1;
    localparam logic [1:0]         RST_VIOL_ACTION   = 2'd0;
    localparam logic [ERRNO_W-1:0] RST_ERROR_NUMBER  = 12'd1;
    localparam logic               RST_AUTO_TRACK    = 1'b0;

    // policy table select
    localparam logic TSEL_SYSCALL = 1'b0;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] context_req;
        logic [5:0] parent_context;
        logic       has_parent;
        logic [9:0] syscall_number;
        logic       compat_abi;
        logic [3:0] target_state;
        logic [3:0] table_state;
        logic       table_select;
        logic [8:0] table_index;
        logic       table_bit;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         status;
        logic               kill_process;
        logic [ERRNO_W-1:0] error_return;
        logic [3:0]         context_state;
        logic               context_tracked;
    } t_out_item;

    typedef struct packed {
        logic               learning_mode;
        logic [1:0]         viol_action;
        logic [ERRNO_W-1:0] error_number;
        logic               auto_track;
    } t_cfg;

    typedef enum logic [2:0] {
        K_SYSCALL,
        K_TRANSITION,
        K_TRACK,
        K_UNTRACK,
        K_LOAD,
        K_NONE
    } t_kind;

    // classified item as it travels through the queue
    typedef struct packed {
        t_kind    kind;
        logic     ctx_ok;
        logic     par_ok;
        logic     sc_ok;
        logic     tgt_ok;
        logic     tstate_ok;
        logic     tidx_sys_ok;
        logic     tidx_st_ok;
        t_in_item item;
    } t_dec;

    // one context slot: tracked flag and current state
    typedef struct packed {
        logic               trk;
        logic [STATE_W-1:0] st;
    } t_ctx_ent;

endpackage

### design/ssff_front.sv
// front part: accepts input items and classifies them for the back part
// depends on ssff_pkg

module ssff_front #(
    parameter int NUM_SYSCALLS = ssff_pkg::DEF_NUM_SYSCALLS,
    parameter int NUM_STATES   = ssff_pkg::DEF_NUM_STATES,
    parameter int NUM_CONTEXTS = ssff_pkg::DEF_NUM_CONTEXTS
) (
    input  logic              i_in_valid,
    input  ssff_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_push,
    output ssff_pkg::t_dec    o_push_item
);
    import ssff_pkg::*;

    t_kind w_kind;

    always_comb begin
        case (i_in_item.cmd)
            CMD_SYSCALL:    w_kind = K_SYSCALL;
            CMD_TRANSITION: w_kind = K_TRANSITION;
            CMD_TRACK:      w_kind = K_TRACK;
            CMD_UNTRACK:    w_kind = K_UNTRACK;
            CMD_LOAD:       w_kind = K_LOAD;
            default:        w_kind = K_NONE;
        endcase
    end

    assign o_in_stall = i_q_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_push_item.kind        = w_kind;
        o_push_item.ctx_ok      = 32'(i_in_item.context_req) < NUM_CONTEXTS;
        o_push_item.par_ok      = 32'(i_in_item.parent_context) < NUM_CONTEXTS;
        o_push_item.sc_ok       = 32'(i_in_item.syscall_number) < NUM_SYSCALLS;
        o_push_item.tgt_ok      = 32'(i_in_item.target_state) < NUM_STATES;
        o_push_item.tstate_ok   = 32'(i_in_item.table_state) < NUM_STATES;
        o_push_item.tidx_sys_ok = 32'(i_in_item.table_index) < NUM_SYSCALLS;
        o_push_item.tidx_st_ok  = 32'(i_in_item.table_index) < NUM_STATES;
        o_push_item.item        = i_in_item;
    end

endmodule

### design/ssff_fifo.sv
// short queue of classified items between front and back
// depends on ssff_pkg

module ssff_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssff_pkg::t_dec i_push_item,
    output logic           o_full,
    output logic           o_valid,
    output ssff_pkg::t_dec o_head,
    input  logic           i_pop
);
    import ssff_pkg::*;

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_dec            r_slot [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count, n_count;

    assign o_full  = r_count == CNTW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

### design/ssff_back.sv
// back part: context and policy stores, per-item sequencer and result register
// depends on ssff_pkg

module ssff_back #(
    parameter int NUM_SYSCALLS = ssff_pkg::DEF_NUM_SYSCALLS,
    parameter int NUM_STATES   = ssff_pkg::DEF_NUM_STATES,
    parameter int NUM_CONTEXTS = ssff_pkg::DEF_NUM_CONTEXTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssff_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  ssff_pkg::t_dec      i_q_item,
    output logic                o_q_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    output ssff_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import ssff_pkg::*;

    localparam int CW          = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int ST_W        = $clog2(NUM_STATES);
    localparam int ALLOW_DEPTH = NUM_STATES * NUM_SYSCALLS;
    localparam int AW          = $clog2(ALLOW_DEPTH);
    localparam int CLR_N       = (ALLOW_DEPTH > NUM_CONTEXTS) ? ALLOW_DEPTH : NUM_CONTEXTS;
    localparam int KW          = $clog2(CLR_N);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_bstate;

    t_bstate r_state, n_state;
    logic [KW-1:0] r_clr, n_clr;

    // stores
    t_ctx_ent              r_ctx_mem [NUM_CONTEXTS];
    logic                  r_sys_mem [ALLOW_DEPTH];
    logic [NUM_STATES-1:0] r_trans   [NUM_STATES];

    // item in flight
    t_dec          r_dec;
    logic [CW-1:0] r_ctx_idx;
    t_ctx_ent      r_cm_c;
    t_ctx_ent      r_cm_p;
    logic [AW-1:0] r_sys_addr;
    logic          r_sys_bit;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    logic            w_pop;
    logic [CW+5:0]   w_ctx_x;
    logic [CW+5:0]   w_par_x;
    logic [CW-1:0]   w_ctx_idx;
    logic [CW-1:0]   w_par_idx;
    logic [STATE_W-1:0] w_sys_row;
    logic [AW-1:0]   w_sys_col;
    logic [AW-1:0]   w_sys_addr;

    logic [ST_W+3:0] w_cur_x;
    logic [ST_W+3:0] w_tgt_x;
    logic [ST_W+3:0] w_tst_x;
    logic [ST_W-1:0] w_cur_idx;
    logic [ST_W-1:0] w_tgt_idx;
    logic [ST_W-1:0] w_tst_idx;
    logic            w_tr_bit;
    logic            w_start;
    logic            w_trk_c;

    logic [3:0]         w_status;
    logic               w_kill;
    logic [ERRNO_W-1:0] w_err;
    t_ctx_ent           w_new;
    logic               w_ctx_wr;
    logic               w_sys_we;
    logic               w_sys_wd;
    logic               w_tr_we;
    logic [ST_W-1:0]    w_tr_row;
    logic [ST_W-1:0]    w_tr_col;
    logic               w_tr_wd;
    t_out_item          w_res;

    logic          w_cm_we;
    logic [CW-1:0] w_cm_addr;
    t_ctx_ent      w_cm_wd;
    logic          w_sm_we;
    logic [AW-1:0] w_sm_addr;
    logic          w_sm_wd;
    logic          w_clr_ctx;
    logic          w_clr_sys;

    assign o_clearing  = r_state == S_CLEAR;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // next item only when the result register will be free by the update cycle
    assign w_pop   = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = w_pop;

    assign w_ctx_x   = {CW'(0), i_q_item.item.context_req};
    assign w_par_x   = {CW'(0), i_q_item.item.parent_context};
    assign w_ctx_idx = w_ctx_x[CW-1:0];
    assign w_par_idx = w_par_x[CW-1:0];

    // allow bit address: row is the policy state, column the syscall number (table state and index for a load)
    assign w_sys_row  = (r_dec.kind == K_LOAD) ? r_dec.item.table_state : r_cm_c.st;
    assign w_sys_col  = (r_dec.kind == K_LOAD) ? AW'(r_dec.item.table_index)
                                               : AW'(r_dec.item.syscall_number);
    assign w_sys_addr = AW'(AW'(w_sys_row) * AW'(NUM_SYSCALLS)) + w_sys_col;

    assign w_cur_x   = {ST_W'(0), r_cm_c.st};
    assign w_tgt_x   = {ST_W'(0), r_dec.item.target_state};
    assign w_tst_x   = {ST_W'(0), r_dec.item.table_state};
    assign w_cur_idx = w_cur_x[ST_W-1:0];
    assign w_tgt_idx = w_tgt_x[ST_W-1:0];
    assign w_tst_idx = w_tst_x[ST_W-1:0];
    assign w_tr_bit  = r_trans[w_cur_idx][w_tgt_idx];

    assign w_trk_c = r_dec.ctx_ok && r_cm_c.trk;
    assign w_start = r_dec.ctx_ok && !r_cm_c.trk && i_cfg.auto_track
                     && (r_dec.kind == K_SYSCALL || r_dec.kind == K_TRANSITION);

    always_comb begin
        w_status = ST_IGNORED;
        w_kill   = 1'b0;
        w_err    = '0;
        w_new.trk = w_trk_c;
        w_new.st  = w_trk_c ? r_cm_c.st : '0;
        w_ctx_wr = 1'b0;
        w_sys_we = 1'b0;
        w_sys_wd = 1'b0;
        w_tr_we  = 1'b0;
        w_tr_row = w_cur_idx;
        w_tr_col = w_tgt_idx;
        w_tr_wd  = 1'b0;
        case (r_dec.kind)
            K_SYSCALL: begin
                if (w_start) begin
                    w_new.trk = 1'b1;
                    w_new.st  = '0;
                    w_ctx_wr  = 1'b1;
                end
                if (w_trk_c || w_start) begin
                    if (r_dec.item.compat_abi) begin
                        w_status = ST_COMPAT;
                    end else if (!r_dec.sc_ok) begin
                        w_status = ST_BADNUM;
                    end else if (i_cfg.learning_mode) begin
                        w_sys_we = 1'b1;
                        w_sys_wd = 1'b1;
                        w_status = ST_RECORDED;
                    end else if (!r_sys_bit) begin
                        w_status = ST_REFUSED;
                    end else begin
                        w_status = ST_ALLOWED;
                    end
                    if (!i_cfg.learning_mode && w_status != ST_ALLOWED) begin
                        if (i_cfg.viol_action != 2'd0) begin
                            w_err = i_cfg.error_number;
                        end
                        // kill for action two and above
                        w_kill = i_cfg.viol_action[1];
                    end
                end
            end
            K_TRANSITION: begin
                if (w_start) begin
                    // the event starts tracking in its target state, zero if out of range
                    w_new.trk = 1'b1;
                    w_new.st  = r_dec.tgt_ok ? r_dec.item.target_state : '0;
                    w_ctx_wr  = 1'b1;
                    w_status  = ST_ALLOWED;
                end else if (w_trk_c) begin
                    if (i_cfg.learning_mode) begin
                        if (r_cm_c.st == r_dec.item.target_state) begin
                            w_status = ST_RECORDED;
                        end else if (r_dec.tgt_ok) begin
                            w_tr_we  = 1'b1;
                            w_tr_wd  = 1'b1;
                            w_new.st = r_dec.item.target_state;
                            w_ctx_wr = 1'b1;
                            w_status = ST_RECORDED;
                        end else begin
                            w_status = ST_FLOW_VIOL;
                        end
                    end else if (r_cm_c.st == r_dec.item.target_state
                                 || (r_dec.tgt_ok && w_tr_bit)) begin
                        w_new.st = r_dec.item.target_state;
                        w_ctx_wr = 1'b1;
                        w_status = ST_ALLOWED;
                    end else if (!i_cfg.auto_track || r_cm_c.st != '0) begin
                        w_status = ST_FLOW_VIOL;
                        w_kill   = 1'b1;
                    end else begin
                        w_status = ST_FLOW_WARN;
                        if (r_dec.tgt_ok) begin
                            w_new.st = r_dec.item.target_state;
                            w_ctx_wr = 1'b1;
                        end
                    end
                end
            end
            K_TRACK: begin
                w_status = ST_ADMIN;
                if (r_dec.ctx_ok && !r_cm_c.trk) begin
                    if (!r_dec.item.has_parent) begin
                        w_new.trk = 1'b1;
                        w_new.st  = '0;
                        w_ctx_wr  = 1'b1;
                    end else if (r_dec.par_ok && r_cm_p.trk) begin
                        w_new.trk = 1'b1;
                        w_new.st  = r_cm_p.st;
                        w_ctx_wr  = 1'b1;
                    end
                end
            end
            K_UNTRACK: begin
                w_status = ST_ADMIN;
                if (r_dec.ctx_ok) begin
                    w_new    = '0;
                    w_ctx_wr = 1'b1;
                end
            end
            K_LOAD: begin
                w_status = ST_ADMIN;
                w_tr_row = w_tst_idx;
                w_tr_col = r_dec.item.table_index[ST_W-1:0];
                if (r_dec.tstate_ok) begin
                    if (r_dec.item.table_select == TSEL_SYSCALL) begin
                        w_sys_we = r_dec.tidx_sys_ok;
                        w_sys_wd = r_dec.item.table_bit;
                    end else begin
                        w_tr_we = r_dec.tidx_st_ok;
                        w_tr_wd = r_dec.item.table_bit;
                    end
                end
            end
            default: begin
                w_status = ST_IGNORED;
            end
        endcase
    end

    always_comb begin
        w_res.status          = w_status;
        w_res.kill_process    = w_kill;
        w_res.error_return    = w_err;
        w_res.context_state   = r_dec.ctx_ok ? w_new.st : '0;
        w_res.context_tracked = r_dec.ctx_ok && w_new.trk;
    end

    // store write ports, shared between the clearing pass and the update cycle
    assign w_clr_ctx = {1'b0, r_clr} < (KW + 1)'(NUM_CONTEXTS);
    assign w_clr_sys = {1'b0, r_clr} < (KW + 1)'(ALLOW_DEPTH);

    always_comb begin
        w_cm_we   = 1'b0;
        w_cm_addr = r_ctx_idx;
        w_cm_wd   = w_new;
        w_sm_we   = 1'b0;
        w_sm_addr = r_sys_addr;
        w_sm_wd   = w_sys_wd;
        if (r_state == S_CLEAR) begin
            w_cm_we   = w_clr_ctx;
            w_cm_addr = r_clr[CW-1:0];
            w_cm_wd   = '0;
            w_sm_we   = w_clr_sys;
            w_sm_addr = r_clr[AW-1:0];
            w_sm_wd   = 1'b0;
        end else if (r_state == S_EXEC) begin
            w_cm_we = w_ctx_wr;
            w_sm_we = w_sys_we;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == KW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_pop) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_EXEC) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // transition table is small enough for flip-flops with a direct clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STATES; i++) begin
                r_trans[i] <= '0;
            end
        end else if (r_state == S_EXEC && w_tr_we) begin
            r_trans[w_tr_row][w_tr_col] <= w_tr_wd;
        end
    end

    // context store: one write port, reads at the item's context and parent
    always_ff @(posedge i_clk) begin
        if (w_cm_we) begin
            r_ctx_mem[w_cm_addr] <= w_cm_wd;
        end
        if (w_pop) begin
            r_cm_c <= r_ctx_mem[w_ctx_idx];
            r_cm_p <= r_ctx_mem[w_par_idx];
        end
    end

    // syscall allow store
    always_ff @(posedge i_clk) begin
        if (w_sm_we) begin
            r_sys_mem[w_sm_addr] <= w_sm_wd;
        end
        if (r_state == S_READ) begin
            r_sys_bit <= r_sys_mem[w_sys_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_dec     <= i_q_item;
            r_ctx_idx <= w_ctx_idx;
        end
        if (r_state == S_READ) begin
            r_sys_addr <= w_sys_addr;
        end
        if (r_state == S_EXEC) begin
            r_out_item <= w_res;
        end
    end

endmodule

### design/stateful_syscall_flow_filter.sv
// channel   direction  handshake                      payload
// in        input      i_in_valid / o_in_stall        i_in_item  (ssff_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall      o_out_item (ssff_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// each item passes the back part in order: context store read, allow store read,
// update and result; the back part takes a new item only after the last one's update,
// and only when the output register will be free by then. the queue holds 2 more
// items. after reset a clearing pass over the context and allow stores runs with
// o_in_stall high; configuration writes are taken. a stalled result holds in the
// output register while the front keeps accepting items until the queue is full.
//
// top level of the per-context syscall and state flow policy checker
// depends on ssff_pkg, ssff_front, ssff_fifo, ssff_back

module stateful_syscall_flow_filter #(
    parameter int NUM_SYSCALLS = ssff_pkg::DEF_NUM_SYSCALLS,
    parameter int NUM_STATES   = ssff_pkg::DEF_NUM_STATES,
    parameter int NUM_CONTEXTS = ssff_pkg::DEF_NUM_CONTEXTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  ssff_pkg::t_in_item                  i_in_item,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output ssff_pkg::t_out_item                 o_out_item,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssff_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssff_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ssff_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_dec w_push_item;
    logic w_q_full;
    logic w_q_valid;
    t_dec w_q_head;
    logic w_q_pop;
    logic w_clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_mode <= RST_LEARNING_MODE;
            r_cfg.viol_action   <= RST_VIOL_ACTION;
            r_cfg.error_number  <= RST_ERROR_NUMBER;
            r_cfg.auto_track    <= RST_AUTO_TRACK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LEARNING_MODE: begin
                    r_cfg.learning_mode <= i_cfg_data[0];
                end
                CFG_VIOL_ACTION: begin
                    r_cfg.viol_action <= i_cfg_data[1:0];
                end
                CFG_ERROR_NUMBER: begin
                    r_cfg.error_number <= i_cfg_data[ERRNO_W-1:0];
                end
                CFG_AUTO_TRACK: begin
                    r_cfg.auto_track <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    ssff_front #(
        .NUM_SYSCALLS (NUM_SYSCALLS),
        .NUM_STATES   (NUM_STATES),
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_q_full    (w_q_full),
        .i_clearing  (w_clearing),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    ssff_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_head      (w_q_head),
        .i_pop       (w_q_pop)
    );

    ssff_back #(
        .NUM_SYSCALLS (NUM_SYSCALLS),
        .NUM_STATES   (NUM_STATES),
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_head),
        .o_q_pop     (w_q_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // no item enters while the stores are being cleared
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_clearing |-> o_in_stall
    ) else $error("item accepted during clearing pass");

    // a kill only comes with a refused syscall or a flow violation
    a_kill_has_cause: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kill_process) |->
        (o_out_item.status == ST_REFUSED || o_out_item.status == ST_COMPAT
         || o_out_item.status == ST_BADNUM || o_out_item.status == ST_FLOW_VIOL)
    ) else $error("kill without a violation");

    // an errno only comes back for a refused syscall
    a_errno_has_cause: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.error_return != '0) |->
        (o_out_item.status == ST_REFUSED || o_out_item.status == ST_COMPAT
         || o_out_item.status == ST_BADNUM)
    ) else $error("errno without a refused syscall");

    // an untracked context always reports state zero
    a_untracked_state_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.context_tracked) |-> (o_out_item.context_state == '0)
    ) else $error("untracked context with nonzero state");

endmodule
